[rtl/core/gsm7_pkg.sv]
// Shared types, constants and the code point to septet mapping of the GSM 7-bit text packer.
// Used by the channel interfaces and by every module of rtl/core.
package gsm7_pkg;

	localparam int CP_W    = 21;
	localparam int SEP_W   = 7;
	localparam int OCT_W   = 8;
	localparam int CNT_W   = 8;
	localparam int PCNT_W  = 3;
	localparam int RES_MAX = 3;

	localparam logic [SEP_W-1:0] ESC_SEPTET = 7'h1B;
	localparam logic [CNT_W-1:0] COUNT_MAX  = 8'hFF;

	// Default depth of the command queue between front and back.
	localparam int QUEUE_DEPTH_DEF = 2;

	typedef enum logic [1:0] {
		KIND_NONE,
		KIND_PLAIN,
		KIND_ESCAPED
	} kind_t;

	typedef struct packed {
		kind_t             kind;
		logic [SEP_W-1:0]  septet;
	} map_t;

	typedef struct packed {
		kind_t             kind;
		logic [SEP_W-1:0]  septet;
		logic              last;
	} cmd_t;

	typedef struct packed {
		logic [OCT_W-1:0]  octet;
		logic              octet_valid;
		logic              message_done;
		logic [CNT_W-1:0]  septet_total;
	} res_t;

	// Maps a code point to a default-alphabet septet, to an extension septet
	// that follows the escape, or to nothing.
	function automatic map_t map_code_point(input logic [CP_W-1:0] cp);
		map_t r;
		r.kind   = KIND_PLAIN;
		r.septet = cp[SEP_W-1:0];
		if (cp inside {[21'h20:21'h23], [21'h25:21'h3F], [21'h41:21'h5A],
				[21'h61:21'h7A], 21'h0A, 21'h0D}) begin
			r.septet = cp[SEP_W-1:0];
		end else begin
			case (cp)
				21'h000040: r.septet = 7'h00;
				21'h0000A3: r.septet = 7'h01;
				21'h000024: r.septet = 7'h02;
				21'h0000A5: r.septet = 7'h03;
				21'h0000E8: r.septet = 7'h04;
				21'h0000E9: r.septet = 7'h05;
				21'h0000F9: r.septet = 7'h06;
				21'h0000EC: r.septet = 7'h07;
				21'h0000F2: r.septet = 7'h08;
				21'h0000C7: r.septet = 7'h09;
				21'h0000D8: r.septet = 7'h0B;
				21'h0000F8: r.septet = 7'h0C;
				21'h0000C5: r.septet = 7'h0E;
				21'h0000E5: r.septet = 7'h0F;
				21'h000394: r.septet = 7'h10;
				21'h00005F: r.septet = 7'h11;
				21'h0003A6: r.septet = 7'h12;
				21'h000393: r.septet = 7'h13;
				21'h00039B: r.septet = 7'h14;
				21'h0003A9: r.septet = 7'h15;
				21'h0003A0: r.septet = 7'h16;
				21'h0003A8: r.septet = 7'h17;
				21'h0003A3: r.septet = 7'h18;
				21'h000398: r.septet = 7'h19;
				21'h00039E: r.septet = 7'h1A;
				21'h0000C6: r.septet = 7'h1C;
				21'h0000E6: r.septet = 7'h1D;
				21'h0000DF: r.septet = 7'h1E;
				21'h0000C9: r.septet = 7'h1F;
				21'h0000A4: r.septet = 7'h24;
				21'h0000A1: r.septet = 7'h40;
				21'h0000C4: r.septet = 7'h5B;
				21'h0000D6: r.septet = 7'h5C;
				21'h0000D1: r.septet = 7'h5D;
				21'h0000DC: r.septet = 7'h5E;
				21'h0000A7: r.septet = 7'h5F;
				21'h0000BF: r.septet = 7'h60;
				21'h0000E4: r.septet = 7'h7B;
				21'h0000F6: r.septet = 7'h7C;
				21'h0000F1: r.septet = 7'h7D;
				21'h0000FC: r.septet = 7'h7E;
				21'h0000E0: r.septet = 7'h7F;
				21'h00000C: begin r.kind = KIND_ESCAPED; r.septet = 7'h0A; end
				21'h00005E: begin r.kind = KIND_ESCAPED; r.septet = 7'h14; end
				21'h00007B: begin r.kind = KIND_ESCAPED; r.septet = 7'h28; end
				21'h00007D: begin r.kind = KIND_ESCAPED; r.septet = 7'h29; end
				21'h00005C: begin r.kind = KIND_ESCAPED; r.septet = 7'h2F; end
				21'h00005B: begin r.kind = KIND_ESCAPED; r.septet = 7'h3C; end
				21'h00007E: begin r.kind = KIND_ESCAPED; r.septet = 7'h3D; end
				21'h00005D: begin r.kind = KIND_ESCAPED; r.septet = 7'h3E; end
				21'h00007C: begin r.kind = KIND_ESCAPED; r.septet = 7'h40; end
				21'h0020AC: begin r.kind = KIND_ESCAPED; r.septet = 7'h65; end
				default: begin r.kind = KIND_NONE; r.septet = '0; end
			endcase
		end
		return r;
	endfunction

endpackage

[rtl/core/gsm7_if.sv]
// Valid/ready channel interfaces of the GSM 7-bit text packer: characters in, octets out.
// Depends on gsm7_pkg for field widths.
interface gsm7_in_if import gsm7_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CP_W-1:0]  code_point;
	logic             end_of_text;

	modport source (output valid, code_point, end_of_text, input ready);
	modport sink (input valid, code_point, end_of_text, output ready);
endinterface

interface gsm7_out_if import gsm7_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OCT_W-1:0] octet;
	logic             octet_valid;
	logic             run_last;
	logic             message_done;
	logic [CNT_W-1:0] septet_total;

	modport source (output valid, octet, octet_valid, run_last, message_done, septet_total,
		input ready);
	modport sink (input valid, octet, octet_valid, run_last, message_done, septet_total,
		output ready);
	modport mon (input valid, ready, octet, octet_valid, run_last, message_done,
		septet_total);
endinterface

[rtl/core/gsm7_front.sv]
// Front end: takes character items, classifies each code point and writes a command.
// Depends on gsm7_pkg and gsm7_in_if.
module gsm7_front import gsm7_pkg::*; (
	gsm7_in_if.sink  chars,
	input  logic     queue_full,
	output logic     push,
	output cmd_t     push_cmd
);

	map_t mapped;

	always_comb begin
		mapped          = map_code_point(chars.code_point);
		push_cmd.kind   = mapped.kind;
		push_cmd.septet = mapped.septet;
		push_cmd.last   = chars.end_of_text;
	end

	assign chars.ready = !queue_full;
	assign push        = chars.valid && !queue_full;

endmodule

[rtl/core/gsm7_cmd_fifo.sv]
// Short command queue that decouples the classifying front end from the packing back end.
// Depends on gsm7_pkg for the command type.
module gsm7_cmd_fifo import gsm7_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic empty,
	output cmd_t head
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cmd_t          slot_q [DEPTH];
	logic [AW-1:0] wr_ptr_q;
	logic [AW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full  = (count_q == CW'(DEPTH));
	assign empty = (count_q == '0);
	assign head  = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[rtl/core/gsm7_back.sv]
// Back end: packs septets into octets, queues up to three results per item, drives the output.
// Depends on gsm7_pkg and gsm7_out_if.
module gsm7_back import gsm7_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_avail,
	input  cmd_t        cmd,
	output logic        pop,
	gsm7_out_if.source  octets
);

	localparam int ACC_W = SEP_W + 2 * SEP_W;

	logic [SEP_W-1:0]  pend_bits_q;
	logic [PCNT_W-1:0] pend_count_q;
	logic [CNT_W-1:0]  septet_count_q;
	res_t              res_q [RES_MAX];
	logic [1:0]        res_n_q;
	logic              out_valid_q;

	logic [1:0]        n_sep;
	logic [2*SEP_W-1:0] sep_bits;
	logic [ACC_W-1:0]  acc;
	logic [ACC_W-1:0]  acc_rest;
	logic [4:0]        total_bits;
	logic [1:0]        n_full;
	logic [PCNT_W-1:0] rem_count;
	logic [SEP_W-1:0]  rem_bits;
	logic [CNT_W:0]    count_sum;
	logic [CNT_W-1:0]  count_new;
	res_t              tail;
	res_t              slot [RES_MAX];
	logic [1:0]        n_new;
	logic              emit;

	always_comb begin
		case (cmd.kind)
			KIND_PLAIN: begin
				n_sep    = 2'd1;
				sep_bits = {{SEP_W{1'b0}}, cmd.septet};
			end
			KIND_ESCAPED: begin
				n_sep    = 2'd2;
				sep_bits = {cmd.septet, ESC_SEPTET};
			end
			default: begin
				n_sep    = 2'd0;
				sep_bits = '0;
			end
		endcase

		// Bits are concatenated least significant first, so the whole item
		// packs in one shift of its septets above the pending bits.
		acc        = ACC_W'(pend_bits_q) | (ACC_W'(sep_bits) << pend_count_q);
		total_bits = 5'(pend_count_q) + ((n_sep == 2'd2) ? 5'd14 :
			(n_sep == 2'd1) ? 5'd7 : 5'd0);
		n_full     = total_bits[4:3];
		rem_count  = total_bits[2:0];
		acc_rest   = acc >> {n_full, 3'b000};
		rem_bits   = acc_rest[SEP_W-1:0];

		count_sum  = {1'b0, septet_count_q} + (CNT_W + 1)'(n_sep);
		count_new  = (count_sum > (CNT_W + 1)'(COUNT_MAX)) ? COUNT_MAX : count_sum[CNT_W-1:0];

		tail.octet        = (rem_count != '0) ? {1'b0, rem_bits} : '0;
		tail.octet_valid  = (rem_count != '0);
		tail.message_done = 1'b0;
		tail.septet_total = '0;

		for (int i = 0; i < RES_MAX; i++) begin
			slot[i] = '0;
		end
		case (n_full)
			2'd0: begin
				slot[0] = tail;
			end
			2'd1: begin
				slot[0] = '{octet: acc[7:0], octet_valid: 1'b1, message_done: 1'b0,
					septet_total: '0};
				slot[1] = tail;
			end
			default: begin
				slot[0] = '{octet: acc[7:0], octet_valid: 1'b1, message_done: 1'b0,
					septet_total: '0};
				slot[1] = '{octet: acc[15:8], octet_valid: 1'b1, message_done: 1'b0,
					septet_total: '0};
				slot[2] = tail;
			end
		endcase

		n_new = n_full + 2'((cmd.last && (rem_count != '0 || n_full == 2'd0)) ? 1 : 0);
		if (cmd.last) begin
			slot[n_new - 2'd1].message_done = 1'b1;
			slot[n_new - 2'd1].septet_total = count_new;
		end
	end

	assign emit = (res_n_q != 2'd0) && (!out_valid_q || octets.ready);
	assign pop  = cmd_avail && ((res_n_q == 2'd0) || (res_n_q == 2'd1 && emit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_bits_q    <= '0;
			pend_count_q   <= '0;
			septet_count_q <= '0;
			res_n_q        <= '0;
			out_valid_q    <= 1'b0;
		end else begin
			if (pop) begin
				res_n_q <= n_new;
				if (cmd.last) begin
					pend_bits_q    <= '0;
					pend_count_q   <= '0;
					septet_count_q <= '0;
				end else begin
					pend_bits_q    <= rem_bits;
					pend_count_q   <= rem_count;
					septet_count_q <= count_new;
				end
			end else if (emit) begin
				res_n_q <= res_n_q - 2'd1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (octets.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			for (int i = 0; i < RES_MAX; i++) begin
				res_q[i] <= slot[i];
			end
		end else if (emit) begin
			for (int i = 0; i < RES_MAX - 1; i++) begin
				res_q[i] <= res_q[i+1];
			end
		end
		if (emit) begin
			octets.octet        <= res_q[0].octet;
			octets.octet_valid  <= res_q[0].octet_valid;
			octets.message_done <= res_q[0].message_done;
			octets.septet_total <= res_q[0].septet_total;
			octets.run_last     <= (res_n_q == 2'd1);
		end
	end

	assign octets.valid = out_valid_q;

endmodule

[rtl/core/gsm7_septet_text_packer_core.sv]
// GSM 7-bit text packer. An accepted item passes through the command queue, the back end's
// result buffer and its output register before its first result appears. The back end pops a
// new item when it holds no result or hands out its last; each item causes 0 to 3 results.
// Reset (arst_n low, asynchronous) empties the queue, drops queued results and clears the
// pending bits and septet counter; the block accepts items in the first cycle after reset.
module gsm7_septet_text_packer_core import gsm7_pkg::*; #(
	parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	gsm7_in_if.sink     chars,
	gsm7_out_if.source  octets
);

	// The front end maps each code point to a command: nothing, one plain
	// septet, or an escape followed by an extension septet. The end of text
	// flag travels with the command.
	logic push;
	cmd_t push_cmd;
	logic queue_full;
	logic queue_empty;
	logic pop;
	cmd_t head;

	gsm7_front u_front (
		.chars      (chars),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	// The queue lets the front keep taking characters while the back end is
	// still draining the octets of an escaped character or a flush.
	gsm7_cmd_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (queue_full),
		.empty    (queue_empty),
		.head     (head)
	);

	// The back end packs a whole command in the cycle it is popped, keeps up
	// to three results in a small buffer and hands them out one per cycle while
	// the output is not stalled. The last result of the message carries the septet count.
	gsm7_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_avail (!queue_empty),
		.cmd       (head),
		.pop       (pop),
		.octets    (octets)
	);

endmodule

[rtl/core/gsm7_checker.sv]
// Port-level checks of the GSM 7-bit text packer output channel, bound to the top level.
// Depends on gsm7_pkg for field widths.
module gsm7_checker import gsm7_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid,
	input  logic             ready,
	input  logic [OCT_W-1:0] octet,
	input  logic             octet_valid,
	input  logic             run_last,
	input  logic             message_done,
	input  logic [CNT_W-1:0] septet_total
);

	a_done_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		valid && message_done |-> run_last)
		else $error("message end does not close the item's run");

	a_total_only_at_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !message_done |-> septet_total == '0)
		else $error("septet total shown before the end of the message");

	a_empty_result_closes: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !octet_valid |-> message_done && octet == '0)
		else $error("result without data outside the end of a message");

	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		valid && !ready |=> valid && $stable(octet)
		&& $stable(octet_valid) && $stable(run_last)
		&& $stable(message_done) && $stable(septet_total))
		else $error("stalled output item changed");

endmodule

bind gsm7_septet_text_packer_core gsm7_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.valid        (octets.valid),
	.ready        (octets.ready),
	.octet        (octets.octet),
	.octet_valid  (octets.octet_valid),
	.run_last     (octets.run_last),
	.message_done (octets.message_done),
	.septet_total (octets.septet_total)
);
